/* rtl/dtc_pkg.sv */
`default_nettype none
package dtc_pkg;

  typedef struct packed {
    logic [6:0]         throttle_percent;
    logic               throttle_ok;
    logic [9:0]         brake_level;
    logic [9:0]         throttle_raw_a;
    logic [9:0]         throttle_raw_b;
    logic               start_button_n;
    logic               safety_loop_open;
    logic               controller_fault;
    logic signed [15:0] motor_speed;
    logic [3:0]         gear_weight;
  } dtc_in_t;

  typedef struct packed {
    logic       drive_ready_led;
    logic       brake_light;
    logic       horn;
    logic [6:0] status_flags;
    logic       torque_send;
    logic [9:0] torque_command;
  } dtc_out_t;

  // per-item result of the tick logic, carried down the torque pipeline
  typedef struct packed {
    logic       drive_ready_led;
    logic       brake_light;
    logic       horn;
    logic [6:0] status_flags;
    logic       period_hit;
    logic       run;
    logic       ready;
    logic [6:0] throttle;
  } dtc_tick_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BEEP_TICKS          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_STEP_LIMIT = 2'd2;

  localparam logic [9:0]  BRAKE_THRESHOLD_RST     = 10'd20;
  localparam logic [15:0] BEEP_TICKS_RST          = 16'd400;
  localparam logic [6:0]  THROTTLE_STEP_LIMIT_RST = 7'd10;

  localparam logic [6:0]  PLAUS_HIGH  = 7'd15;
  localparam logic [9:0]  BRAKE_PLAUS = 10'd15;
  localparam logic [6:0]  PLAUS_LOW   = 7'd5;
  localparam logic [9:0]  RAW_MIN     = 10'd5;

  localparam logic [6:0]  THROTTLE_MAX = 7'd99;
  localparam logic [10:0] GEAR_STEP    = 11'd99;
  localparam logic [14:0] SPEED_TOP    = 15'd4500;
  localparam logic [9:0]  LIMIT_TOP    = 10'd200;
  localparam logic [9:0]  LIMIT_SLOW   = 10'd999;
  localparam logic [14:0] SEG_SPAN     = 15'd300;
  localparam logic [10:0] RISE_STEP    = 11'd50;
  localparam logic [10:0] RISE_FLOOR   = 11'd500;
  localparam logic [10:0] TORQUE_MAX   = 11'd999;

  // x / 3 for x below 2048, x / 25 for x below 43690
  localparam logic [18:0] RECIP3        = 19'd683;
  localparam int          RECIP3_SHIFT  = 11;
  localparam logic [27:0] RECIP25       = 28'd5243;
  localparam int          RECIP25_SHIFT = 17;

  // slope * d / 300 with slope a multiple of 25 reduces to d / 2, 3, 6 or 12
  typedef enum logic [1:0] {
    DIV_HALF,
    DIV_THIRD,
    DIV_SIXTH,
    DIV_TWELFTH
  } seg_div_t;

  localparam int SEG_N = 11;
  localparam logic [12:0] SEG_LOW [SEG_N] = '{
    13'd4200, 13'd3900, 13'd3600, 13'd3300, 13'd3000, 13'd2700,
    13'd2400, 13'd2100, 13'd1800, 13'd1500, 13'd1200
  };
  localparam logic [9:0] SEG_BASE [SEG_N] = '{
    10'd100, 10'd200, 10'd350, 10'd500, 10'd600, 10'd700,
    10'd750, 10'd850, 10'd900, 10'd925, 10'd950
  };
  localparam seg_div_t SEG_DIV [SEG_N] = '{
    DIV_THIRD, DIV_HALF, DIV_HALF, DIV_THIRD, DIV_THIRD, DIV_SIXTH,
    DIV_THIRD, DIV_SIXTH, DIV_TWELFTH, DIV_TWELFTH, DIV_SIXTH
  };

endpackage
`default_nettype wire

/* rtl/dtc_limit.sv */
`default_nettype none
module dtc_limit (
  input  wire logic               clk,
  input  wire logic               advance,
  input  wire logic signed [15:0] motor_speed,
  input  wire logic [3:0]         gear_weight,
  output logic [9:0]              limit_r
);
  import dtc_pkg::*;

  localparam int SEL_W = $clog2(SEG_N);

  logic [14:0]      speed_u;
  logic [SEL_W-1:0] sel;
  logic             seg_hit;
  logic [14:0]      span_top;
  logic [8:0]       diff;
  logic [8:0]       div_in;
  logic [18:0]      div_prod;
  logic [8:0]       quot;
  logic [9:0]       lim;
  logic [10:0]      cap;
  logic [9:0]       limit_nxt;

  always_comb begin
    speed_u = motor_speed[15] ? 15'd0 : motor_speed[14:0];
    sel     = '0;
    seg_hit = 1'b0;
    for (int i = SEG_N - 1; i >= 0; i--) begin
      if (speed_u > 15'(SEG_LOW[i])) begin
        sel     = SEL_W'(i);
        seg_hit = 1'b1;
      end
    end
    span_top = 15'(SEG_LOW[sel]) + SEG_SPAN;
    diff     = 9'(span_top - speed_u);
    case (SEG_DIV[sel])
      DIV_THIRD:   div_in = diff;
      DIV_SIXTH:   div_in = diff >> 1;
      DIV_TWELFTH: div_in = diff >> 2;
      default:     div_in = diff;
    endcase
    div_prod = {10'd0, div_in} * RECIP3;
    if (SEG_DIV[sel] == DIV_HALF) begin
      quot = diff >> 1;
    end else begin
      quot = {1'b0, div_prod[RECIP3_SHIFT +: 8]};
    end
    if (speed_u > SPEED_TOP) begin
      lim = LIMIT_TOP;
    end else if (seg_hit) begin
      lim = SEG_BASE[sel] + 10'(quot);
    end else begin
      lim = LIMIT_SLOW;
    end
    cap = 11'(gear_weight) * GEAR_STEP;
    if ({1'b0, lim} > cap) begin
      limit_nxt = cap[9:0];
    end else begin
      limit_nxt = lim;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      limit_r <= limit_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/dtc_tick.sv */
`default_nettype none
module dtc_tick #(
  parameter int TORQUE_INTERVAL = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             advance,
  input  wire logic             item_valid,
  input  wire dtc_pkg::dtc_in_t item,
  input  wire logic [9:0]       brake_threshold,
  input  wire logic [15:0]      beep_ticks,
  output dtc_pkg::dtc_tick_t    tick_r
);
  import dtc_pkg::*;

  localparam int PW = $clog2(TORQUE_INTERVAL + 1);
  localparam logic [PW-1:0] PERIOD = PW'(TORQUE_INTERVAL);

  logic          start_latched_r, start_latched_nxt;
  logic          plausible_r, plausible_nxt;
  logic          drive_ready_r, drive_ready_nxt;
  logic          horn_armed_r, horn_armed_nxt;
  logic [15:0]   horn_count_r, horn_count_nxt;
  logic [PW-1:0] period_r, period_nxt;
  logic          brake_on, run, fault, horn;
  dtc_tick_t     tick_nxt;

  always_comb begin
    brake_on          = item.brake_level > brake_threshold;
    fault             = item.safety_loop_open | item.controller_fault;
    start_latched_nxt = start_latched_r | (brake_on & ~item.start_button_n);
    plausible_nxt     = plausible_r & ~((item.throttle_percent > PLAUS_HIGH)
                                        & (item.brake_level > BRAKE_PLAUS));
    plausible_nxt     = plausible_nxt | (item.throttle_percent < PLAUS_LOW);
    run = start_latched_nxt & item.throttle_ok & plausible_nxt
          & (item.throttle_raw_a >= RAW_MIN) & (item.throttle_raw_b >= RAW_MIN);
    drive_ready_nxt = drive_ready_r | (run & ~fault);
    horn_armed_nxt  = horn_armed_r | (run & ~fault);
    horn_count_nxt  = horn_count_r;
    if (fault) begin
      start_latched_nxt = 1'b0;
      drive_ready_nxt   = 1'b0;
      horn_armed_nxt    = 1'b0;
      horn_count_nxt    = '0;
    end
    horn = horn_armed_nxt & (horn_count_nxt < beep_ticks);
    if (horn) begin
      horn_count_nxt = horn_count_nxt + 16'd1;
    end
    period_nxt = (period_r >= PERIOD) ? '0 : period_r;
    period_nxt = period_nxt + PW'(1);

    tick_nxt.drive_ready_led = drive_ready_nxt;
    tick_nxt.brake_light     = brake_on;
    tick_nxt.horn            = horn;
    tick_nxt.status_flags    = {brake_on, ~item.safety_loop_open, drive_ready_nxt, run,
                                start_latched_nxt, plausible_nxt, item.throttle_ok};
    tick_nxt.period_hit      = period_nxt == PERIOD;
    tick_nxt.run             = run;
    tick_nxt.ready           = drive_ready_nxt;
    tick_nxt.throttle        = item.throttle_percent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_latched_r <= 1'b0;
      plausible_r     <= 1'b1;
      drive_ready_r   <= 1'b0;
      horn_armed_r    <= 1'b0;
      horn_count_r    <= '0;
      period_r        <= '0;
    end else if (advance && item_valid) begin
      start_latched_r <= start_latched_nxt;
      plausible_r     <= plausible_nxt;
      drive_ready_r   <= drive_ready_nxt;
      horn_armed_r    <= horn_armed_nxt;
      horn_count_r    <= horn_count_nxt;
      period_r        <= period_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tick_r <= tick_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/dtc_torque.sv */
`default_nettype none
module dtc_torque (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire logic               tick_valid,
  input  wire dtc_pkg::dtc_tick_t tick,
  input  wire logic [9:0]         limit,
  input  wire logic [6:0]         step_limit,
  output logic                    out_valid_r,
  output dtc_pkg::dtc_out_t       out_r
);
  import dtc_pkg::*;

  logic [7:0]  last_throttle_r;
  logic [9:0]  last_torque_r;
  logic        v3_r, v4_r;
  dtc_tick_t   tick3_r, tick4_r;
  logic [16:0] prod3_r;
  logic [9:0]  quot4_r;

  logic [7:0]  ac_sum;
  logic [7:0]  ac;
  logic [6:0]  ac_clamped;
  logic [16:0] prod3_nxt;
  logic [27:0] div_prod;
  logic [9:0]  quot4_nxt;
  logic [10:0] torque;
  logic [9:0]  cmd;
  dtc_out_t    out_nxt;

  // throttle step limit, then limit times throttle
  always_comb begin
    ac_sum = {1'b0, tick.throttle} - last_throttle_r;
    if (({1'b0, tick.throttle} > last_throttle_r) && (ac_sum > {1'b0, step_limit})) begin
      ac = last_throttle_r + {1'b0, step_limit};
    end else begin
      ac = {1'b0, tick.throttle};
    end
    ac_clamped = (ac > {1'b0, THROTTLE_MAX}) ? THROTTLE_MAX : ac[6:0];
    prod3_nxt  = 17'(limit) * 17'(ac_clamped);
  end

  // divide by 100
  always_comb begin
    div_prod  = 28'(prod3_r[16:2]) * RECIP25;
    quot4_nxt = div_prod[RECIP25_SHIFT +: 10];
  end

  // rise limit and command
  always_comb begin
    torque = {1'b0, quot4_r};
    if ((quot4_r > last_torque_r) && (torque - {1'b0, last_torque_r} > RISE_STEP)
        && (torque > RISE_FLOOR)) begin
      torque = {1'b0, last_torque_r} + RISE_STEP;
    end
    cmd = (torque > TORQUE_MAX) ? TORQUE_MAX[9:0] : torque[9:0];
    out_nxt.drive_ready_led = tick4_r.drive_ready_led;
    out_nxt.brake_light     = tick4_r.brake_light;
    out_nxt.horn            = tick4_r.horn;
    out_nxt.status_flags    = tick4_r.status_flags;
    out_nxt.torque_send     = tick4_r.period_hit & (~tick4_r.run | tick4_r.ready);
    out_nxt.torque_command  = (tick4_r.period_hit & tick4_r.run & tick4_r.ready) ? cmd : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r            <= 1'b0;
      v4_r            <= 1'b0;
      out_valid_r     <= 1'b0;
      last_throttle_r <= '0;
      last_torque_r   <= '0;
    end else if (advance) begin
      v3_r        <= tick_valid;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
      if (tick_valid && tick.period_hit) begin
        last_throttle_r <= ac;
      end
      if (v4_r && tick4_r.period_hit) begin
        last_torque_r <= torque[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tick3_r <= tick;
      prod3_r <= prod3_nxt;
      tick4_r <= tick3_r;
      quot4_r <= quot4_nxt;
      out_r   <= out_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/drive_enable_torque_command_core.sv */
// items pass the input, tick/limit, product, quotient and output registers
// throughput: one item per cycle; each state register (tick latches, last
// throttle, last torque) is read and written in a single pipeline stage
// the whole pipeline holds while a result waits on out_ready
// reset: synchronous, active low; empties the pipeline and restores state
// and configuration registers to their reset values
`default_nettype none
module drive_enable_torque_command_core #(
  parameter int TORQUE_INTERVAL = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire dtc_pkg::dtc_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output dtc_pkg::dtc_out_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic [dtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dtc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dtc_pkg::*;

  logic        advance;
  logic        v1_r, v2_r;
  dtc_in_t     in_r;
  logic [9:0]  brake_threshold_r;
  logic [15:0] beep_ticks_r;
  logic [6:0]  step_limit_r;
  dtc_tick_t   tick;
  logic [9:0]  limit;

  assign advance  = ~out_valid | out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brake_threshold_r <= BRAKE_THRESHOLD_RST;
      beep_ticks_r      <= BEEP_TICKS_RST;
      step_limit_r      <= THROTTLE_STEP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BRAKE_THRESHOLD:     brake_threshold_r <= cfg_data[9:0];
        CFG_BEEP_TICKS:          beep_ticks_r      <= cfg_data[15:0];
        CFG_THROTTLE_STEP_LIMIT: step_limit_r      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_r <= in_data;
    end
  end

  dtc_tick #(
    .TORQUE_INTERVAL(TORQUE_INTERVAL)
  ) u_tick (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .item_valid     (v1_r),
    .item           (in_r),
    .brake_threshold(brake_threshold_r),
    .beep_ticks     (beep_ticks_r),
    .tick_r         (tick)
  );

  dtc_limit u_limit (
    .clk        (clk),
    .advance    (advance),
    .motor_speed(in_r.motor_speed),
    .gear_weight(in_r.gear_weight),
    .limit_r    (limit)
  );

  dtc_torque u_torque (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .tick_valid (v2_r),
    .tick       (tick),
    .limit      (limit),
    .step_limit (step_limit_r),
    .out_valid_r(out_valid),
    .out_r      (out_data)
  );

endmodule
`default_nettype wire

/* rtl/dtc_checker.sv */
`default_nettype none
module dtc_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire dtc_pkg::dtc_out_t out_data
);
  import dtc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_cmd_needs_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.torque_command != 10'd0 |->
      out_data.torque_send && out_data.torque_command <= TORQUE_MAX[9:0])
    else $error("torque command without send or out of range");

  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.drive_ready_led == out_data.status_flags[4]
      && out_data.brake_light == out_data.status_flags[6])
    else $error("lamp outputs disagree with status flags");

endmodule

bind drive_enable_torque_command_core dtc_checker u_dtc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire
